@@ hdl/slv_pkg.sv @@
// Shared constants and types for the satellite link visibility block.
`timescale 1ns / 1ps

package slv_pkg;

    localparam int COORD_BITS_DEFAULT = 17;

    localparam int RANGE_BITS     = 18;
    localparam int RADIUS_BITS    = 16;
    localparam int RANGE_SQ_BITS  = 2 * RANGE_BITS;
    localparam int RADIUS_SQ_BITS = 2 * RADIUS_BITS;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = RANGE_BITS;

    localparam logic [RANGE_BITS-1:0]  RANGE_RESET  = RANGE_BITS'(5000);
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(6371);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_LINK_RANGE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_EARTH_RADIUS   = CFG_IDX_BITS'(1);

    localparam int NUM_STAGES = 7;

    // Per-stage load enables of the item pipeline
    typedef struct packed {
        logic diff;   // stage 1: endpoints and separation vector
        logic prod;   // stage 2: component products
        logic sum;    // stage 3: dot products and squared norms
        logic part;   // stage 4: tests and partial products
        logic acc;    // stage 5: wide products
        logic add;    // stage 6: right-hand sum
        logic fin;    // stage 7: output register
    } slv_adv_t;

endpackage

@@ hdl/slv_if.sv @@
// Channel interfaces: position pair items, link results, configuration writes.
`timescale 1ns / 1ps

interface slv_item_if #(
    parameter int COORD_BITS = slv_pkg::COORD_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] first_z;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] second_z;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
        output ready
    );
endinterface

interface slv_result_if;
    logic valid;
    logic ready;
    logic visible;
    logic out_of_range;
    logic blocked;

    modport source (
        output valid, visible, out_of_range, blocked,
        input  ready
    );
    modport sink (
        input  valid, visible, out_of_range, blocked,
        output ready
    );
endinterface

interface slv_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [slv_pkg::CFG_IDX_BITS-1:0]   index;
    logic [slv_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ hdl/slv_wide_mul.sv @@
// Two-stage unsigned multiplier built from four half-width partial products.
`timescale 1ns / 1ps

module slv_wide_mul #(
    parameter int A_BITS = 36,
    parameter int B_BITS = 36
) (
    input  logic                       clk,
    input  slv_pkg::slv_adv_t          adv,
    input  logic [A_BITS-1:0]          a,
    input  logic [B_BITS-1:0]          b,
    output logic [A_BITS+B_BITS-1:0]   prod
);
    import slv_pkg::*;

    localparam int LA = (A_BITS + 1) / 2;
    localparam int HA = A_BITS - LA;
    localparam int LB = (B_BITS + 1) / 2;
    localparam int HB = B_BITS - LB;
    localparam int PW = A_BITS + B_BITS;

    logic [LA+LB-1:0] p_ll_next, p_ll_reg;
    logic [LA+HB-1:0] p_lh_next, p_lh_reg;
    logic [HA+LB-1:0] p_hl_next, p_hl_reg;
    logic [HA+HB-1:0] p_hh_next, p_hh_reg;
    logic [PW-1:0]    prod_next, prod_reg;

    assign p_ll_next = (LA+LB)'(a[LA-1:0])      * (LA+LB)'(b[LB-1:0]);
    assign p_lh_next = (LA+HB)'(a[LA-1:0])      * (LA+HB)'(b[B_BITS-1:LB]);
    assign p_hl_next = (HA+LB)'(a[A_BITS-1:LA]) * (HA+LB)'(b[LB-1:0]);
    assign p_hh_next = (HA+HB)'(a[A_BITS-1:LA]) * (HA+HB)'(b[B_BITS-1:LB]);

    // Recombine the partial products at their weights
    assign prod_next = PW'(p_ll_reg)
                     + (PW'(p_lh_reg) << LB)
                     + (PW'(p_hl_reg) << LA)
                     + (PW'(p_hh_reg) << (LA + LB));

    always_ff @(posedge clk)
    begin
        if (adv.part)
        begin
            p_ll_reg <= p_ll_next;
            p_lh_reg <= p_lh_next;
            p_hl_reg <= p_hl_next;
            p_hh_reg <= p_hh_next;
        end
        if (adv.acc)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

@@ hdl/slv_front.sv @@
// Front stages: separation vector, component products, dot products and norms.
`timescale 1ns / 1ps

module slv_front #(
    parameter int COORD_BITS = slv_pkg::COORD_BITS_DEFAULT
) (
    input  logic                           clk,
    input  slv_pkg::slv_adv_t              adv,
    input  logic signed [COORD_BITS-1:0]   first_x,
    input  logic signed [COORD_BITS-1:0]   first_y,
    input  logic signed [COORD_BITS-1:0]   first_z,
    input  logic signed [COORD_BITS-1:0]   second_x,
    input  logic signed [COORD_BITS-1:0]   second_y,
    input  logic signed [COORD_BITS-1:0]   second_z,
    output logic [2*COORD_BITS+1:0]        sep_sq,
    output logic signed [2*COORD_BITS+1:0] proj,
    output logic [2*COORD_BITS-1:0]        first_sq,
    output logic [2*COORD_BITS-1:0]        second_sq
);
    import slv_pkg::*;

    localparam int N     = COORD_BITS;
    localparam int VW    = N + 1;        // separation component
    localparam int VSQ_W = 2 * N;        // square of a separation component
    localparam int AV_W  = 2 * N + 1;    // first position times separation
    localparam int PSQ_W = 2 * N - 1;    // square of a position component
    localparam int SUM_W = 2 * N + 2;

    // Stage 1
    logic signed [N-1:0]  ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [VW-1:0] vx_next, vy_next, vz_next;
    logic signed [VW-1:0] vx_reg, vy_reg, vz_reg;

    // Stage 2
    logic [VSQ_W-1:0]       vsq_x_next, vsq_y_next, vsq_z_next;
    logic [VSQ_W-1:0]       vsq_x_reg, vsq_y_reg, vsq_z_reg;
    logic signed [AV_W-1:0] av_x_next, av_y_next, av_z_next;
    logic signed [AV_W-1:0] av_x_reg, av_y_reg, av_z_reg;
    logic [PSQ_W-1:0]       asq_x_next, asq_y_next, asq_z_next;
    logic [PSQ_W-1:0]       asq_x_reg, asq_y_reg, asq_z_reg;
    logic [PSQ_W-1:0]       bsq_x_next, bsq_y_next, bsq_z_next;
    logic [PSQ_W-1:0]       bsq_x_reg, bsq_y_reg, bsq_z_reg;

    // Stage 3
    logic [SUM_W-1:0]        sep_sq_next, sep_sq_reg;
    logic signed [SUM_W-1:0] proj_next, proj_reg;
    logic [2*N-1:0]          first_sq_next, first_sq_reg;
    logic [2*N-1:0]          second_sq_next, second_sq_reg;

    assign vx_next = VW'(second_x) - VW'(first_x);
    assign vy_next = VW'(second_y) - VW'(first_y);
    assign vz_next = VW'(second_z) - VW'(first_z);

    assign vsq_x_next = VSQ_W'(vx_reg) * VSQ_W'(vx_reg);
    assign vsq_y_next = VSQ_W'(vy_reg) * VSQ_W'(vy_reg);
    assign vsq_z_next = VSQ_W'(vz_reg) * VSQ_W'(vz_reg);

    assign av_x_next = AV_W'(ax_reg) * AV_W'(vx_reg);
    assign av_y_next = AV_W'(ay_reg) * AV_W'(vy_reg);
    assign av_z_next = AV_W'(az_reg) * AV_W'(vz_reg);

    assign asq_x_next = PSQ_W'(ax_reg) * PSQ_W'(ax_reg);
    assign asq_y_next = PSQ_W'(ay_reg) * PSQ_W'(ay_reg);
    assign asq_z_next = PSQ_W'(az_reg) * PSQ_W'(az_reg);
    assign bsq_x_next = PSQ_W'(bx_reg) * PSQ_W'(bx_reg);
    assign bsq_y_next = PSQ_W'(by_reg) * PSQ_W'(by_reg);
    assign bsq_z_next = PSQ_W'(bz_reg) * PSQ_W'(bz_reg);

    assign sep_sq_next = SUM_W'(vsq_x_reg) + SUM_W'(vsq_y_reg) + SUM_W'(vsq_z_reg);
    // Projection term is the negated dot product of first position and separation
    assign proj_next   = SUM_W'(0) - SUM_W'(av_x_reg) - SUM_W'(av_y_reg)
                       - SUM_W'(av_z_reg);
    assign first_sq_next  = (2*N)'(asq_x_reg) + (2*N)'(asq_y_reg) + (2*N)'(asq_z_reg);
    assign second_sq_next = (2*N)'(bsq_x_reg) + (2*N)'(bsq_y_reg) + (2*N)'(bsq_z_reg);

    always_ff @(posedge clk)
    begin
        if (adv.diff)
        begin
            ax_reg <= first_x;
            ay_reg <= first_y;
            az_reg <= first_z;
            bx_reg <= second_x;
            by_reg <= second_y;
            bz_reg <= second_z;
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            vz_reg <= vz_next;
        end
        if (adv.prod)
        begin
            vsq_x_reg <= vsq_x_next;
            vsq_y_reg <= vsq_y_next;
            vsq_z_reg <= vsq_z_next;
            av_x_reg  <= av_x_next;
            av_y_reg  <= av_y_next;
            av_z_reg  <= av_z_next;
            asq_x_reg <= asq_x_next;
            asq_y_reg <= asq_y_next;
            asq_z_reg <= asq_z_next;
            bsq_x_reg <= bsq_x_next;
            bsq_y_reg <= bsq_y_next;
            bsq_z_reg <= bsq_z_next;
        end
        if (adv.sum)
        begin
            sep_sq_reg    <= sep_sq_next;
            proj_reg      <= proj_next;
            first_sq_reg  <= first_sq_next;
            second_sq_reg <= second_sq_next;
        end
    end

    assign sep_sq    = sep_sq_reg;
    assign proj      = proj_reg;
    assign first_sq  = first_sq_reg;
    assign second_sq = second_sq_reg;

endmodule

@@ hdl/satellite_link_visibility.sv @@
// Top level of the satellite link visibility block: pipeline control and decision.
`timescale 1ns / 1ps

// Channel  | Modport | Beat carries
// ---------+---------+-----------------------------------------------------------
// item     | sink    | first_x/y/z, second_x/y/z, signed kilometres
// result   | source  | visible, out_of_range, blocked
// cfg      | sink    | index (0 range, 1 radius), data; always ready
//
// Cycles: one item per clock while results are taken. The depth is set by the
// wide products of the interior test, each split into half-width partial products
// over two stages. Reset clears stage valid bits and loads the range and radius
// registers with their defaults; there is no clearing pass. A stalled result holds
// stage 7 and back-pressure collapses bubbles stage by stage, so input stays open
// while any stage is empty.
//
// Test: out of range when |P2-P1|^2 > range^2. Otherwise the nearest point of the
// segment to the origin is P1 (coincident points or projection at or before P1),
// P2 (projection at or past P2), or interior, where |P1|^2*c2 > c1^2 + radius^2*c2
// decides clear. A distance equal to the radius counts as blocked.

module satellite_link_visibility #(
    parameter int COORD_BITS = slv_pkg::COORD_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    slv_item_if.sink     item,
    slv_result_if.source result,
    slv_cfg_if.sink      cfg
);
    import slv_pkg::*;

    localparam int N      = COORD_BITS;
    localparam int SEP_W  = 2 * N + 2;
    localparam int PSQ_W  = 2 * N;
    localparam int FAR_W  = (SEP_W > RANGE_SQ_BITS) ? SEP_W : RANGE_SQ_BITS;
    localparam int END_W  = (PSQ_W > RADIUS_SQ_BITS) ? PSQ_W : RADIUS_SQ_BITS;
    localparam int LHS_W  = PSQ_W + SEP_W;
    localparam int C1SQ_W = 2 * SEP_W;
    localparam int E2C_W  = RADIUS_SQ_BITS + SEP_W;
    localparam int RHS_M  = (C1SQ_W > E2C_W) ? C1SQ_W : E2C_W;
    localparam int CMP_W  = ((RHS_M > LHS_W) ? RHS_M : LHS_W) + 1;

    // Configuration registers and their squares
    logic [RANGE_BITS-1:0]     range_reg;
    logic [RADIUS_BITS-1:0]    radius_reg;
    logic [RANGE_SQ_BITS-1:0]  range_sq_next, range_sq_reg;
    logic [RADIUS_SQ_BITS-1:0] radius_sq_next, radius_sq_reg;

    // Pipeline control
    logic [NUM_STAGES-1:0] valid_reg, valid_next, stage_adv;
    slv_adv_t              adv;

    // Front results (stage 3)
    logic [SEP_W-1:0]        sep_sq;
    logic signed [SEP_W-1:0] proj;
    logic [PSQ_W-1:0]        first_sq, second_sq;

    // Stage 4
    logic far_next, far4_reg;
    logic interior_next, interior4_reg;
    logic near_clear_next, near_clear4_reg;
    logic proj_not_pos, proj_past_end;

    // Stage 5
    logic far5_reg, interior5_reg, near_clear5_reg;
    logic [LHS_W-1:0]  lhs_prod;
    logic [C1SQ_W-1:0] c1sq_prod;
    logic [E2C_W-1:0]  e2c_prod;

    // Stage 6
    logic far6_reg, interior6_reg, near_clear6_reg;
    logic [CMP_W-1:0] lhs6_reg, rhs_next, rhs6_reg;

    // Stage 7
    logic clear_next;
    logic visible_reg, out_of_range_reg, blocked_reg;

    // Configuration writes; an unknown index is dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg  <= RANGE_RESET;
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_MAX_LINK_RANGE: range_reg  <= cfg.data;
                REG_EARTH_RADIUS:   radius_reg <= cfg.data[RADIUS_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Squares are registered; writes must only land while idle, as the user ensures
    assign range_sq_next  = RANGE_SQ_BITS'(range_reg) * RANGE_SQ_BITS'(range_reg);
    assign radius_sq_next = RADIUS_SQ_BITS'(radius_reg) * RADIUS_SQ_BITS'(radius_reg);

    always_ff @(posedge clk)
    begin
        range_sq_reg  <= range_sq_next;
        radius_sq_reg <= radius_sq_next;
    end

    // A stage advances when it is empty or the stage after it advances
    assign stage_adv[6] = !valid_reg[6] || result.ready;
    assign stage_adv[5] = !valid_reg[5] || stage_adv[6];
    assign stage_adv[4] = !valid_reg[4] || stage_adv[5];
    assign stage_adv[3] = !valid_reg[3] || stage_adv[4];
    assign stage_adv[2] = !valid_reg[2] || stage_adv[3];
    assign stage_adv[1] = !valid_reg[1] || stage_adv[2];
    assign stage_adv[0] = !valid_reg[0] || stage_adv[1];

    assign adv.diff = stage_adv[0];
    assign adv.prod = stage_adv[1];
    assign adv.sum  = stage_adv[2];
    assign adv.part = stage_adv[3];
    assign adv.acc  = stage_adv[4];
    assign adv.add  = stage_adv[5];
    assign adv.fin  = stage_adv[6];

    assign item.ready = stage_adv[0];

    // Advance valid bits where a stage loads, hold them where it stalls
    assign valid_next = (stage_adv & {valid_reg[NUM_STAGES-2:0], item.valid})
                      | (~stage_adv & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stages 1 to 3
    slv_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .adv       (adv),
        .first_x   (item.first_x),
        .first_y   (item.first_y),
        .first_z   (item.first_z),
        .second_x  (item.second_x),
        .second_y  (item.second_y),
        .second_z  (item.second_z),
        .sep_sq    (sep_sq),
        .proj      (proj),
        .first_sq  (first_sq),
        .second_sq (second_sq)
    );

    // Stage 4: range test and endpoint classification
    assign far_next      = FAR_W'(sep_sq) > FAR_W'(range_sq_reg);
    assign proj_not_pos  = proj[SEP_W-1] || (proj == '0);
    // Only consulted when the projection is positive, so the bits read unsigned
    assign proj_past_end = $unsigned(proj) >= sep_sq;
    // Coincident points give a zero projection and land on the first endpoint
    assign interior_next = !proj_not_pos && !proj_past_end;
    assign near_clear_next = proj_not_pos
                           ? (END_W'(first_sq)  > END_W'(radius_sq_reg))
                           : (END_W'(second_sq) > END_W'(radius_sq_reg));

    // Stages 4 and 5: wide products of the interior test
    slv_wide_mul #(
        .A_BITS (PSQ_W),
        .B_BITS (SEP_W)
    ) u_mul_lhs (
        .clk  (clk),
        .adv  (adv),
        .a    (first_sq),
        .b    (sep_sq),
        .prod (lhs_prod)
    );

    slv_wide_mul #(
        .A_BITS (SEP_W),
        .B_BITS (SEP_W)
    ) u_mul_proj (
        .clk  (clk),
        .adv  (adv),
        .a    ($unsigned(proj)),
        .b    ($unsigned(proj)),
        .prod (c1sq_prod)
    );

    slv_wide_mul #(
        .A_BITS (RADIUS_SQ_BITS),
        .B_BITS (SEP_W)
    ) u_mul_radius (
        .clk  (clk),
        .adv  (adv),
        .a    (radius_sq_reg),
        .b    (sep_sq),
        .prod (e2c_prod)
    );

    // Stage 6: right-hand sum
    assign rhs_next = CMP_W'(c1sq_prod) + CMP_W'(e2c_prod);

    // Stage 7: final verdict
    assign clear_next = interior6_reg ? (lhs6_reg > rhs6_reg) : near_clear6_reg;

    always_ff @(posedge clk)
    begin
        if (adv.part)
        begin
            far4_reg        <= far_next;
            interior4_reg   <= interior_next;
            near_clear4_reg <= near_clear_next;
        end
        if (adv.acc)
        begin
            far5_reg        <= far4_reg;
            interior5_reg   <= interior4_reg;
            near_clear5_reg <= near_clear4_reg;
        end
        if (adv.add)
        begin
            far6_reg        <= far5_reg;
            interior6_reg   <= interior5_reg;
            near_clear6_reg <= near_clear5_reg;
            lhs6_reg        <= CMP_W'(lhs_prod);
            rhs6_reg        <= rhs_next;
        end
        if (adv.fin)
        begin
            visible_reg      <= !far6_reg && clear_next;
            out_of_range_reg <= far6_reg;
            blocked_reg      <= !far6_reg && !clear_next;
        end
    end

    assign result.valid        = valid_reg[NUM_STAGES-1];
    assign result.visible      = visible_reg;
    assign result.out_of_range = out_of_range_reg;
    assign result.blocked      = blocked_reg;

    // Exactly one verdict flag per result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> $onehot({result.visible, result.out_of_range, result.blocked}))
    else $error("result flags not one-hot");

    // Input closes only when every stage is full and the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> ((&valid_reg) && !result.ready))
    else $error("input stalled with a free stage");

    // A full, stalled pipeline drops nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && !result.ready) |=> (&valid_reg))
    else $error("item lost during stall");

    // A range write lands in the range register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready && cfg.index == REG_MAX_LINK_RANGE)
        |=> (range_reg == $past(cfg.data)))
    else $error("range write not taken");

endmodule

@@ test/satellite_link_visibility_tb.sv @@
// Self-checking testbench for the satellite link visibility block.
`timescale 1ns / 1ps

module satellite_link_visibility_tb;

    import slv_pkg::*;

    localparam int      COORD_BITS = COORD_BITS_DEFAULT;
    localparam longint  COORD_MAX  = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint  COORD_MIN  = -(longint'(1) << (COORD_BITS - 1));
    localparam int      LATENCY    = NUM_STAGES;

    typedef struct {
        logic signed [COORD_BITS-1:0] ax, ay, az;
        logic signed [COORD_BITS-1:0] bx, by, bz;
    } pos_pair_t;

    typedef struct {
        logic visible;
        logic out_of_range;
        logic blocked;
    } link_verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    slv_item_if #(.COORD_BITS(COORD_BITS)) item_ch ();
    slv_result_if                          result_ch ();
    slv_cfg_if                             cfg_ch ();

    satellite_link_visibility #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Mirror of the range and radius registers, updated on each accepted cfg beat
    logic [RANGE_BITS-1:0]  range_km_q  = RANGE_RESET;
    logic [RADIUS_BITS-1:0] radius_km_q = RADIUS_RESET;

    pos_pair_t     pending_pairs[$];    // position pairs not yet offered to the block
    link_verdict_t pending_verdicts[$]; // verdicts owed for accepted pairs, oldest first

    int fail_count    = 0;
    int send_idle_pct = 0;              // chance per beat of a valid-low burst
    int recv_idle_pct = 0;              // chance per cycle of a ready-low burst
    int send_gap      = 0;
    int recv_stall    = 0;

    // Append at the tail of the pending queues
    function automatic void enqueue_pair(pos_pair_t p);
        pending_pairs.insert(pending_pairs.size(), p);
    endfunction

    function automatic void enqueue_verdict(link_verdict_t v);
        pending_verdicts.insert(pending_verdicts.size(), v);
    endfunction

    // Free-running clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Drive every block input to a known value from time zero
    initial
    begin
        item_ch.valid    = 1'b0;
        item_ch.first_x  = '0;
        item_ch.first_y  = '0;
        item_ch.first_z  = '0;
        item_ch.second_x = '0;
        item_ch.second_y = '0;
        item_ch.second_z = '0;
        result_ch.ready  = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
    end

    function automatic pos_pair_t pair_at(longint ax, longint ay, longint az,
                                          longint bx, longint by, longint bz);
        pos_pair_t p;
        p.ax = COORD_BITS'(ax);
        p.ay = COORD_BITS'(ay);
        p.az = COORD_BITS'(az);
        p.bx = COORD_BITS'(bx);
        p.by = COORD_BITS'(by);
        p.bz = COORD_BITS'(bz);
        return p;
    endfunction

    // Exact segment-versus-sphere test on squared integers, 128-bit where the
    // interior projection needs |P1|^2*c2 against c1^2 + radius^2*c2.
    function automatic link_verdict_t judge_link(pos_pair_t p);
        longint        ax, ay, az, bx, by, bz;
        longint        vx, vy, vz;
        longint        sep_sq, range_sq, radius_sq, proj, start_sq, end_sq;
        logic [127:0]  lhs, rhs, w_start, w_sep, w_proj, w_radius;
        logic          far, clear;
        link_verdict_t v;
        ax = p.ax;  ay = p.ay;  az = p.az;
        bx = p.bx;  by = p.by;  bz = p.bz;
        vx = bx - ax;
        vy = by - ay;
        vz = bz - az;
        sep_sq    = vx * vx + vy * vy + vz * vz;
        range_sq  = longint'(range_km_q) * longint'(range_km_q);
        radius_sq = longint'(radius_km_q) * longint'(radius_km_q);
        far       = sep_sq > range_sq;
        clear     = 1'b1;
        if (!far)
        begin
            proj     = -(ax * vx + ay * vy + az * vz);
            start_sq = ax * ax + ay * ay + az * az;
            end_sq   = bx * bx + by * by + bz * bz;
            if (sep_sq == 0 || proj <= 0)
                clear = start_sq > radius_sq;       // nearest point is P1
            else if (proj >= sep_sq)
                clear = end_sq > radius_sq;         // nearest point is P2
            else
            begin
                w_start  = start_sq;
                w_sep    = sep_sq;
                w_proj   = proj;
                w_radius = radius_sq;
                lhs      = w_start * w_sep;
                rhs      = w_proj * w_proj + w_radius * w_sep;
                clear    = lhs > rhs;
            end
        end
        v.visible      = !far && clear;
        v.out_of_range = far;
        v.blocked      = !far && !clear;
        return v;
    endfunction

    function automatic longint clamp_coord(longint c);
        if (c > COORD_MAX)
            return COORD_MAX;
        if (c < COORD_MIN)
            return COORD_MIN;
        return c;
    endfunction

    function automatic longint jitter(longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    // Mostly pairs near the sphere with separations near the range, so that
    // in-range, blocked and grazing cases all show up; a tenth are raw bit
    // patterns and a tenth coincident points.
    function automatic pos_pair_t make_pair();
        pos_pair_t   p;
        int unsigned kind;
        longint      shell, span, ax, ay, az;
        kind  = $urandom_range(0, 9);
        shell = longint'(radius_km_q) + longint'(radius_km_q) / 4 + 64;
        span  = (kind >= 8) ? longint'(range_km_q) + 16 : longint'(range_km_q) / 2 + 1;
        if (kind == 0)
        begin
            p.ax = COORD_BITS'($urandom());
            p.ay = COORD_BITS'($urandom());
            p.az = COORD_BITS'($urandom());
            p.bx = COORD_BITS'($urandom());
            p.by = COORD_BITS'($urandom());
            p.bz = COORD_BITS'($urandom());
            return p;
        end
        ax = clamp_coord(jitter(shell));
        ay = clamp_coord(jitter(shell));
        az = clamp_coord(jitter(shell));
        if (kind == 1)
            return pair_at(ax, ay, az, ax, ay, az);
        return pair_at(ax, ay, az,
                       clamp_coord(ax + jitter(span)),
                       clamp_coord(ay + jitter(span)),
                       clamp_coord(az + jitter(span)));
    endfunction

    // Item driver: hold a beat until it is taken, then advance to the next
    // pending pair or drop valid for a random burst.
    always @(posedge clk)
    begin : feed_positions
        pos_pair_t next_pair;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                enqueue_verdict(judge_link(pair_at(
                    item_ch.first_x, item_ch.first_y, item_ch.first_z,
                    item_ch.second_x, item_ch.second_y, item_ch.second_z)));
            if (!item_ch.valid || item_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap      <= send_gap - 1;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_pairs.size() != 0)
                begin
                    next_pair         = pending_pairs.pop_front();
                    item_ch.first_x  <= next_pair.ax;
                    item_ch.first_y  <= next_pair.ay;
                    item_ch.first_z  <= next_pair.az;
                    item_ch.second_x <= next_pair.bx;
                    item_ch.second_y <= next_pair.by;
                    item_ch.second_z <= next_pair.bz;
                    item_ch.valid    <= 1'b1;
                    if ($urandom_range(0, 99) < send_idle_pct)
                        send_gap <= $urandom_range(1, 15);
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each accepted beat against the oldest verdict
    // and stall ready in random bursts.
    always @(posedge clk)
    begin : check_verdicts
        link_verdict_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("result beat with no position pair outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (result_ch.visible !== want.visible)
                    begin
                        $error("visible: expected %0b, got %0b",
                               want.visible, result_ch.visible);
                        fail_count++;
                    end
                    if (result_ch.out_of_range !== want.out_of_range)
                    begin
                        $error("out_of_range: expected %0b, got %0b",
                               want.out_of_range, result_ch.out_of_range);
                        fail_count++;
                    end
                    if (result_ch.blocked !== want.blocked)
                    begin
                        $error("blocked: expected %0b, got %0b",
                               want.blocked, result_ch.blocked);
                        fail_count++;
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall      <= recv_stall - 1;
                result_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < recv_idle_pct)
            begin
                recv_stall      <= $urandom_range(1, 15) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Write one register and mirror it once the beat is taken; the block is
    // idle whenever this runs.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_MAX_LINK_RANGE)
            range_km_q = val[RANGE_BITS-1:0];
        else if (idx == REG_EARTH_RADIUS)
            radius_km_q = val[RADIUS_BITS-1:0];
    endtask

    // Every pair yields one beat, so an empty verdict queue means idle
    task automatic wait_drained();
        while (pending_pairs.size() != 0 || item_ch.valid || pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        repeat (count)
            enqueue_pair(make_pair());
    endtask

    initial
    begin : run_phases
        int phase;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 15;
        recv_idle_pct = 10;

        // Directed pairs under the reset range and radius
        enqueue_pair(pair_at(COORD_MIN, COORD_MIN, COORD_MIN,
                             COORD_MIN, COORD_MIN, COORD_MIN));
        enqueue_pair(pair_at(COORD_MAX, COORD_MAX, COORD_MAX,
                             COORD_MAX, COORD_MAX, COORD_MAX));
        enqueue_pair(pair_at(0, 0, 0, 0, 0, 0));
        enqueue_pair(pair_at(COORD_MIN, COORD_MIN, COORD_MIN,
                             COORD_MAX, COORD_MAX, COORD_MAX));
        // grazing chord: nearest approach exactly on the radius, then one past it
        enqueue_pair(pair_at(-2000, 6371, 0, 2000, 6371, 0));
        enqueue_pair(pair_at(-2000, 6372, 0, 2000, 6372, 0));
        enqueue_pair(pair_at(-2000, 100, 0, 2000, 100, 0));
        // projection before the start, past the end, and ending inside
        enqueue_pair(pair_at(7000, 0, 0, 10000, 0, 0));
        enqueue_pair(pair_at(10000, 0, 0, 7000, 0, 0));
        enqueue_pair(pair_at(10000, 0, 0, 6000, 0, 0));
        // projection exactly at the start and exactly at the end
        enqueue_pair(pair_at(6371, 0, 0, 6371, 3000, 0));
        enqueue_pair(pair_at(6372, 0, 0, 6372, 3000, 0));
        enqueue_pair(pair_at(6371, -3000, 0, 6371, 0, 0));
        enqueue_pair(pair_at(6372, -3000, 0, 6372, 0, 0));
        // separation exactly on the range, then just beyond
        enqueue_pair(pair_at(0, 0, 10000, 3000, 4000, 10000));
        enqueue_pair(pair_at(0, 0, 10000, 3000, 4001, 10000));
        queue_random(200);
        wait_drained();

        // Widest range; radius written with spare upper data bits set
        write_reg(REG_MAX_LINK_RANGE, '1);
        write_reg(REG_EARTH_RADIUS, {2'b11, 16'd6371});
        queue_random(200);
        wait_drained();

        // Zero range and radius, with no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_MAX_LINK_RANGE, '0);
        write_reg(REG_EARTH_RADIUS, '0);
        enqueue_pair(pair_at(0, 0, 0, 0, 0, 0));
        enqueue_pair(pair_at(1, 0, 0, 1, 0, 0));
        queue_random(100);
        wait_drained();

        // Widest range and radius
        send_idle_pct = 25;
        recv_idle_pct = 25;
        write_reg(REG_MAX_LINK_RANGE, '1);
        write_reg(REG_EARTH_RADIUS, '1);
        queue_random(200);
        wait_drained();

        // Unused indexes must leave both registers alone
        write_reg(CFG_IDX_BITS'(2), CFG_DATA_BITS'($urandom()));
        write_reg(CFG_IDX_BITS'(3), CFG_DATA_BITS'($urandom()));

        for (phase = 0; phase < 5; phase++)
        begin
            send_idle_pct = (phase == 4) ? 0 : $urandom_range(5, 30);
            recv_idle_pct = (phase == 4) ? 0 : $urandom_range(5, 30);
            if (phase != 0)
            begin
                write_reg(REG_MAX_LINK_RANGE, CFG_DATA_BITS'($urandom_range(0, 140000)));
                write_reg(REG_EARTH_RADIUS, CFG_DATA_BITS'($urandom_range(0, 65535)));
            end
            queue_random(100);
            wait_drained();
        end

        // Leave room for any stray beat to show up
        repeat (4 * LATENCY)
            @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
